// ===== sv/stp_pkg.sv =====
`default_nettype none
package stp_pkg;

  localparam int NOTE_W   = 16;
  localparam int POS_W    = 32;
  localparam int SPEED_W  = 16;
  localparam int ACCEL_W  = 16;
  localparam int EXP_W    = 3;
  localparam int CFG_W    = 16;
  localparam int PERIOD_W = 16;

  localparam int MAX_SHIFT = (1 << EXP_W) - 1;

  localparam int TIMES10_W   = NOTE_W + 3;
  localparam int SCALED_W    = TIMES10_W + MAX_SHIFT;
  localparam int RECIP_SHIFT = SCALED_W + 3;
  localparam int RECIP_W     = SCALED_W;
  localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'(((1 << RECIP_SHIFT) + 8) / 9);
  localparam int PROD_W      = SCALED_W + RECIP_W;
  localparam int QUOT9_W     = PROD_W - RECIP_SHIFT;

  localparam int ERR_W = POS_W + 1;
  localparam int LHS_W = 1 + ACCEL_W + POS_W;
  localparam int RHS_W = 2 * SPEED_W + MAX_SHIFT;

  localparam logic [SPEED_W-1:0] CLOCK_DIV = SPEED_W'(30);
  localparam int PERIOD_NUM = 129600000;
  localparam int PNUM_W     = $clog2(PERIOD_NUM + 1);
  localparam int DEN_W      = 2 * SPEED_W;
  localparam int DIV_CNT_W  = $clog2(PNUM_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = DIV_CNT_W'(PNUM_W - 1);

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_STEP   = 2'd1,
    CMD_RAMP   = 2'd2,
    CMD_HOLD   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_MICROSTEP = 2'd0,
    CFG_ACCEL     = 2'd1,
    CFG_FLOOR     = 2'd2,
    CFG_CEILING   = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TGT_MUL,
    ST_TGT_SIGN,
    ST_ERR,
    ST_BRAKE_MUL,
    ST_BRAKE,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [NOTE_W-1:0] note;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    forward;
    logic                    stepping;
    logic                    ramping;
    logic                    speeding_up;
    logic                    braking_zone;
    logic [SPEED_W-1:0]      speed_now;
    logic [PERIOD_W-1:0]     step_period;
    logic                    at_target;
  } result_t;

  typedef struct packed {
    logic [EXP_W-1:0]   microstep_exp;
    logic [ACCEL_W-1:0] accel_limit;
    logic [SPEED_W-1:0] speed_floor;
    logic [SPEED_W-1:0] speed_ceiling;
  } cfg_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic tgt_mul;
    logic tgt_sign;
    logic err_calc;
    logic brake_mul;
    logic brake;
    logic div_load;
    logic div_step;
  } ctl_t;

  typedef struct packed {
    cmd_e command;
    logic err_zero;
    logic div_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/stepper_trapezoid_profile.sv =====
`default_nettype none
// Sequence: a beat is executed, and an update then forms the target (multiply, sign), the
//   error, the braking multiply and the braking decision (skipped when already on target);
//   every command ends in the 27-step period divider. Beats are worked one at a time; a new
//   beat is taken while the previous result still waits in the output register, and a
//   result held there stalls the next one in its last state.
// Reset (rst, synchronous): position, target and speed clear, direction up, all
//   run flags clear, registers return to their defaults; no clearing pass.
module stepper_trapezoid_profile
  import stp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire item_t            cmd_data,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output result_t               res_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cfg_t    cfg;
  ctl_t    ctl;
  sts_t    sts;
  result_t result;
  logic    out_free;
  logic    out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.microstep_exp <= '0;
      cfg.accel_limit   <= ACCEL_W'(1000);
      cfg.speed_floor   <= SPEED_W'(64);
      cfg.speed_ceiling <= SPEED_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_MICROSTEP: cfg.microstep_exp <= cfg_data[EXP_W-1:0];
        CFG_ACCEL:     cfg.accel_limit   <= cfg_data[ACCEL_W-1:0];
        CFG_FLOOR:     cfg.speed_floor   <= cfg_data[SPEED_W-1:0];
        CFG_CEILING:   cfg.speed_ceiling <= cfg_data[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) res_data <= result;
  end

  stp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .out_free  (out_free),
    .out_load  (out_load),
    .sts       (sts),
    .ctl       (ctl)
  );

  stp_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (cmd_data),
    .cfg    (cfg),
    .sts    (sts),
    .result (result)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("beat taken while previous beat still in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!res_valid || res_ready))
    else $error("pending result overwritten");

  a_zero_speed_period: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.speed_now == '0) |-> (res_data.step_period == {PERIOD_W{1'b1}}))
    else $error("period not saturated at zero speed");

  a_brake_slows: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.braking_zone && res_data.ramping |-> !res_data.speeding_up)
    else $error("ramp accelerating inside braking zone");
`endif

endmodule
`default_nettype wire

// ===== sv/stp_ctrl.sv =====
`default_nettype none
module stp_ctrl
  import stp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire logic out_free,
  output logic      out_load,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = (sts.command == CMD_UPDATE) ? ST_TGT_MUL : ST_DIV_LOAD;
      end
      ST_TGT_MUL:   state_next = ST_TGT_SIGN;
      ST_TGT_SIGN:  state_next = ST_ERR;
      ST_ERR:       state_next = ST_BRAKE_MUL;
      ST_BRAKE_MUL: state_next = sts.err_zero ? ST_DIV_LOAD : ST_BRAKE;
      ST_BRAKE:     state_next = ST_DIV_LOAD;
      ST_DIV_LOAD:  state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (sts.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    cmd_ready = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_ready     = 1'b1;
        ctl.load_item = cmd_valid;
      end
      ST_EXEC:      ctl.exec = 1'b1;
      ST_TGT_MUL:   ctl.tgt_mul = 1'b1;
      ST_TGT_SIGN:  ctl.tgt_sign = 1'b1;
      ST_ERR:       ctl.err_calc = 1'b1;
      ST_BRAKE_MUL: ctl.brake_mul = 1'b1;
      ST_BRAKE:     ctl.brake = 1'b1;
      ST_DIV_LOAD:  ctl.div_load = 1'b1;
      ST_DIV_RUN:   ctl.div_step = 1'b1;
      ST_DONE:      out_load = out_free;
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/stp_dpath.sv =====
`default_nettype none
module stp_dpath
  import stp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire ctl_t  ctl,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output sts_t       sts,
  output result_t    result
);

  logic [POS_W-1:0]   step_count;
  logic [POS_W-1:0]   target_pos;
  logic               dir_up;
  logic               run_steps;
  logic               run_ramp;
  logic               ramp_up;
  logic               in_brake;
  logic [SPEED_W-1:0] cur_speed;

  cmd_e               cmd_code;
  logic [NOTE_W-1:0]  note_r;
  logic               note_neg;
  logic [SCALED_W-1:0] scaled;
  logic [PROD_W-1:0]  prod;
  logic [POS_W-1:0]   err_mag;
  logic               err_zero;
  logic               err_pos;
  logic [LHS_W-1:0]   lhs;
  logic [RHS_W-1:0]   rhs;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   rem;
  logic [PNUM_W-1:0]  quot;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [NOTE_W-1:0]    note_abs;
  logic [TIMES10_W-1:0] abs_ext;
  logic [TIMES10_W-1:0] times10;
  logic [QUOT9_W-1:0]   quot9;
  logic [POS_W-1:0]     quot9_ext;
  logic [ERR_W-1:0]     err_full;
  logic [ERR_W-1:0]     err_neg;
  logic [ACCEL_W+POS_W-1:0] brake_prod;
  logic [DEN_W-1:0]     spd_sq;
  logic                 brake_hit;
  logic [DEN_W:0]       rem_shift;
  logic [DEN_W:0]       rem_diff;
  logic                 fits;
  logic [PNUM_W-1:0]    period_shift;
  logic [PERIOD_W-1:0]  period;

  assign note_abs  = note_r[NOTE_W-1] ? (~note_r + NOTE_W'(1)) : note_r;
  assign abs_ext   = {3'b000, note_abs};
  assign times10   = (abs_ext << 3) + (abs_ext << 1);
  assign quot9     = prod[PROD_W-1 -: QUOT9_W];
  assign quot9_ext = {{(POS_W-QUOT9_W){1'b0}}, quot9};
  assign err_full  = {target_pos[POS_W-1], target_pos} - {step_count[POS_W-1], step_count};
  assign err_neg   = ~err_full + ERR_W'(1);
  assign brake_prod = {{POS_W{1'b0}}, cfg.accel_limit} * {{ACCEL_W{1'b0}}, err_mag};
  assign spd_sq    = {{SPEED_W{1'b0}}, cur_speed} * {{SPEED_W{1'b0}}, cur_speed};
  assign brake_hit = lhs <= {{(LHS_W-RHS_W){1'b0}}, rhs};
  assign rem_shift = {rem, quot[PNUM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, den};
  assign fits      = rem_shift >= {1'b0, den};
  assign period_shift = quot >> cfg.microstep_exp;
  assign period    = (|period_shift[PNUM_W-1:PERIOD_W]) ? {PERIOD_W{1'b1}}
                                                        : period_shift[PERIOD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
      target_pos <= '0;
      dir_up     <= 1'b1;
      run_steps  <= 1'b0;
      run_ramp   <= 1'b0;
      ramp_up    <= 1'b0;
      in_brake   <= 1'b0;
      cur_speed  <= '0;
      cmd_code   <= CMD_HOLD;
      div_cnt    <= '0;
    end else begin
      if (ctl.load_item) cmd_code <= cmd_e'(item.command);
      if (ctl.exec) begin
        unique case (cmd_code)
          CMD_STEP: begin
            if (run_steps) step_count <= dir_up ? step_count + POS_W'(1)
                                                : step_count - POS_W'(1);
          end
          CMD_RAMP: begin
            if (run_ramp) begin
              if (ramp_up) begin
                if (cur_speed != {SPEED_W{1'b1}}) cur_speed <= cur_speed + SPEED_W'(1);
              end else begin
                if (cur_speed != '0) cur_speed <= cur_speed - SPEED_W'(1);
              end
            end
          end
          CMD_UPDATE, CMD_HOLD: begin
          end
          default: begin
          end
        endcase
      end
      if (ctl.tgt_sign) target_pos <= note_neg ? (~quot9_ext + POS_W'(1)) : quot9_ext;
      if (ctl.brake_mul) begin
        run_steps <= !err_zero;
        if (!err_zero) dir_up <= err_pos;
      end
      if (ctl.brake) begin
        in_brake <= brake_hit;
        if (brake_hit) begin
          if (cur_speed <= cfg.speed_floor) begin
            run_ramp <= 1'b0;
          end else begin
            ramp_up  <= 1'b0;
            run_ramp <= 1'b1;
          end
        end else begin
          if (cur_speed <= cfg.speed_ceiling) begin
            ramp_up  <= 1'b1;
            run_ramp <= 1'b1;
          end else begin
            run_ramp <= 1'b0;
          end
        end
      end
      if (ctl.div_load) begin
        div_cnt <= DIV_LAST_CNT;
      end else if (ctl.div_step) begin
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) note_r <= item.note;
    if (ctl.exec) begin
      note_neg <= note_r[NOTE_W-1];
      scaled   <= {{MAX_SHIFT{1'b0}}, times10} << cfg.microstep_exp;
    end
    if (ctl.tgt_mul) prod <= {{RECIP_W{1'b0}}, scaled} * {{SCALED_W{1'b0}}, RECIP_NINE};
    if (ctl.err_calc) begin
      err_zero <= (err_full == '0);
      err_pos  <= !err_full[ERR_W-1];
      err_mag  <= err_full[ERR_W-1] ? err_neg[POS_W-1:0] : err_full[POS_W-1:0];
    end
    if (ctl.brake_mul) begin
      lhs <= {brake_prod, 1'b0};
      rhs <= {{MAX_SHIFT{1'b0}}, spd_sq} << cfg.microstep_exp;
    end
    if (ctl.div_load) begin
      den  <= {{SPEED_W{1'b0}}, CLOCK_DIV} * {{SPEED_W{1'b0}}, cur_speed};
      rem  <= '0;
      quot <= PNUM_W'(PERIOD_NUM);
    end else if (ctl.div_step) begin
      rem  <= fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      quot <= {quot[PNUM_W-2:0], fits};
    end
  end

  always_comb begin
    sts.command  = cmd_code;
    sts.err_zero = err_zero;
    sts.div_last = (div_cnt == '0);
  end

  always_comb begin
    result.position     = step_count;
    result.forward      = dir_up;
    result.stepping     = run_steps;
    result.ramping      = run_ramp;
    result.speeding_up  = ramp_up;
    result.braking_zone = in_brake;
    result.speed_now    = cur_speed;
    result.step_period  = period;
    result.at_target    = (step_count == target_pos);
  end

endmodule
`default_nettype wire
